>>> design/wbss_pkg.sv
// ============================================================================
// wbss_pkg: shared types and constants for the wildcard byte signature scanner
// This package holds the item structs, the configuration bundle and the
// register index codes.
// ============================================================================
`default_nettype none

package wbss_pkg;

  // Signature positions and derived widths.
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int POS_W             = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_W             = 5;
  localparam int ADDR_W            = 48;
  localparam int DATA_W            = 64;
  localparam int PADDR_W           = 5;

  // Register index codes, taken from paddr[4:3].
  localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [1:0] REG_WILDCARD     = 2'd2;
  localparam logic [1:0] REG_LENGTH       = 2'd3;

  // One scanned byte with its address.
  typedef struct packed {
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              region_end;
  } scan_item_t;

  // One scan result.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } result_item_t;

  // Configuration bundle from the register block to the matcher.
  typedef struct packed {
    logic [63:0]                  pattern_bytes_low;
    logic [63:0]                  pattern_bytes_high;
    logic [MAX_PATTERN_BYTES-1:0] wildcard_mask;
    logic [LEN_W-1:0]             pattern_length;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/wbss_cfg_regs.sv
// ============================================================================
// wbss_cfg_regs: configuration registers
// APB-style register block holding the signature bytes, the wildcard mask
// and the signature length. Registers sit at byte addresses 0, 8, 16, 24.
// ============================================================================
`default_nettype none

module wbss_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wbss_pkg::PADDR_W-1:0] paddr,
  input  wire logic [wbss_pkg::DATA_W-1:0]  pwdata,
  output logic      [wbss_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output wbss_pkg::cfg_t                   cfg
);
  import wbss_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:3];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes_low  <= '0;
      cfg.pattern_bytes_high <= '0;
      cfg.wildcard_mask      <= '0;
      cfg.pattern_length     <= LEN_W'(1);
    end else if (wr_en) begin
      case (reg_index)
        REG_PATTERN_LOW:  cfg.pattern_bytes_low  <= pwdata;
        REG_PATTERN_HIGH: cfg.pattern_bytes_high <= pwdata;
        REG_WILDCARD:     cfg.wildcard_mask      <= pwdata[MAX_PATTERN_BYTES-1:0];
        REG_LENGTH:       cfg.pattern_length     <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_index)
      REG_PATTERN_LOW:  prdata = cfg.pattern_bytes_low;
      REG_PATTERN_HIGH: prdata = cfg.pattern_bytes_high;
      REG_WILDCARD:     prdata = DATA_W'(cfg.wildcard_mask);
      REG_LENGTH:       prdata = DATA_W'(cfg.pattern_length);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/wbss_matcher.sv
// ============================================================================
// wbss_matcher: input register and shift-and match step
// Holds the latest byte in an input register, updates the partial match
// vector in one step and hands any result to the output register.
// ============================================================================
`default_nettype none

module wbss_matcher (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire wbss_pkg::cfg_t        cfg,
  input  wire logic                  scan_valid,
  output logic                       scan_stall,
  input  wire wbss_pkg::scan_item_t  scan_item,
  input  wire logic                  out_free,
  output logic                       res_push,
  output wbss_pkg::result_item_t     res_item
);
  import wbss_pkg::*;

  logic                         s0_valid;
  scan_item_t                   s0_item;
  logic [MAX_PATTERN_BYTES-1:0] partial_match_vector;
  logic                         search_done;

  logic [POS_W-1:0]             last_pos;
  logic [8*MAX_PATTERN_BYTES-1:0] sig_bytes;
  logic [MAX_PATTERN_BYTES-1:0] hits;
  logic [MAX_PATTERN_BYTES-1:0] vec_next;
  logic                         hit;
  logic                         has_result;
  logic                         advance;

  // Effective length minus one: zero acts as one, oversize clamps to the max.
  always_comb begin
    if (cfg.pattern_length == '0) begin
      last_pos = '0;
    end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES)) begin
      last_pos = POS_W'(MAX_PATTERN_BYTES - 1);
    end else begin
      last_pos = POS_W'(cfg.pattern_length - LEN_W'(1));
    end
  end

  assign sig_bytes = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

  // Per-position byte compare; positions past the length never hit.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      hits[i] = (POS_W'(i) <= last_pos) &&
                (cfg.wildcard_mask[i] || (sig_bytes[8*i +: 8] == s0_item.data_byte));
    end
  end

  // Shift-and step and result decision.
  assign vec_next   = {partial_match_vector[MAX_PATTERN_BYTES-2:0], 1'b1} & hits;
  assign hit        = vec_next[last_pos];
  assign has_result = !search_done && (hit || s0_item.region_end);
  assign advance    = s0_valid && (!has_result || out_free);
  assign scan_stall = s0_valid && !advance;
  assign res_push   = advance && has_result;

  always_comb begin
    res_item.found = hit;
    if (hit) begin
      res_item.match_address = s0_item.byte_address - ADDR_W'(last_pos);
    end else begin
      res_item.match_address = '0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (scan_valid && !scan_stall) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_valid && !scan_stall) begin
      s0_item <= scan_item;
    end
  end

  // Match state update as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_match_vector <= '0;
      search_done          <= 1'b0;
    end else if (advance) begin
      if (search_done) begin
        if (s0_item.region_end) begin
          partial_match_vector <= '0;
          search_done          <= 1'b0;
        end
      end else if (hit) begin
        partial_match_vector <= '0;
        search_done          <= !s0_item.region_end;
      end else if (s0_item.region_end) begin
        partial_match_vector <= '0;
      end else begin
        partial_match_vector <= vec_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/wbss_out_reg.sv
// ============================================================================
// wbss_out_reg: result register
// Holds one result item until the downstream side takes it.
// ============================================================================
`default_nettype none

module wbss_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   res_push,
  input  wire wbss_pkg::result_item_t res_item,
  output logic                        out_free,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output wbss_pkg::result_item_t      result_item
);
  import wbss_pkg::*;

  // The register can take a new item when empty or being drained.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      result_item <= res_item;
    end
  end

endmodule

`default_nettype wire

>>> design/wildcard_byte_signature_scan_top.sv
// Timing: a result item is loaded into the result register as its byte leaves
// the input register, where the byte is held once it is accepted.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, and a byte that gives a result waits only while a
// previous result is held by downstream stall.
// Reset (rst, synchronous): clears the match state and valid flags; length = 1.
// ============================================================================
// wildcard_byte_signature_scan_top: wildcard byte signature scanner
// Scans a region byte by byte with shift-and matching and reports the start
// address of the first match, or not-found at the end of the region.
// ============================================================================
`default_nettype none

module wildcard_byte_signature_scan_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wbss_pkg::PADDR_W-1:0] paddr,
  input  wire logic [wbss_pkg::DATA_W-1:0]  pwdata,
  output logic      [wbss_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         scan_valid,
  output logic                              scan_stall,
  input  wire wbss_pkg::scan_item_t         scan_item,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output wbss_pkg::result_item_t            result_item
);
  import wbss_pkg::*;

  cfg_t         cfg;
  logic         out_free;
  logic         res_push;
  result_item_t res_item;

  // Configuration registers.
  wbss_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Match step.
  wbss_matcher u_matcher (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .scan_item  (scan_item),
    .out_free   (out_free),
    .res_push   (res_push),
    .res_item   (res_item)
  );

  // Result register.
  wbss_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res_push     (res_push),
    .res_item     (res_item),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

`default_nettype wire
